@@ design/dirac_parse_info_deframer_defines.svh @@
// assertion macros used by the deframer core
`ifndef DIRAC_PARSE_INFO_DEFRAMER_DEFINES_SVH
`define DIRAC_PARSE_INFO_DEFRAMER_DEFINES_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define DPI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, disabled in reset
`define DPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dpi_pkg.sv @@
// types, constants and helpers of the parse-info deframer
`default_nettype none
package dpi_pkg;

  localparam int DPI_OFFSET_BITS = 32;

  localparam logic [31:0] PREFIX_WORD = 32'h4242_4344;
  localparam logic [31:0] HEADER_LEN  = 32'd13;

  // header byte positions
  localparam logic [3:0] HDR_CODE_IDX  = 4'd4;
  localparam logic [3:0] HDR_NEXT_LAST = 4'd8;
  localparam logic [3:0] HDR_LAST      = 4'd12;

  // parse codes with a meaning of their own
  localparam logic [7:0] PC_SEQ_HDR = 8'h00;
  localparam logic [7:0] PC_EOS     = 8'h10;
  localparam logic [7:0] PC_AUX     = 8'h20;
  localparam logic [7:0] PC_PAD     = 8'h30;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    EV_HUNT      = 3'd0,
    EV_HDR_BYTE  = 3'd1,
    EV_HDR_DONE  = 3'd2,
    EV_PAYLOAD   = 3'd3,
    EV_SYNC_LOST = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    KIND_SEQ_HDR  = 3'd0,
    KIND_EOS      = 3'd1,
    KIND_AUX      = 3'd2,
    KIND_PAD      = 3'd3,
    KIND_PICTURE  = 3'd4,
    KIND_RESERVED = 3'd5
  } kind_t;

  typedef struct packed {
    event_t      event_res;
    kind_t       packet_kind;
    logic [7:0]  pkt_code;
    logic [31:0] next_offset;
    logic [31:0] prev_offset;
    logic [7:0]  payload_byte;
    logic        packet_done;
    logic        accepted;
    logic [31:0] picture_count;
  } dpi_result_t;

  // classify a parse code
  function automatic kind_t kind_of(input logic [7:0] code);
    kind_t k;
    case (code)
      PC_SEQ_HDR: k = KIND_SEQ_HDR;
      PC_EOS:     k = KIND_EOS;
      PC_AUX:     k = KIND_AUX;
      PC_PAD:     k = KIND_PAD;
      default: begin
        if (code inside {8'h0C, 8'h08, 8'h4C, 8'h48, 8'h0D, 8'h0E, 8'h09, 8'h0A,
                         8'hCC, 8'hC8}) begin
          k = KIND_PICTURE;
        end else begin
          k = KIND_RESERVED;
        end
      end
    endcase
    return k;
  endfunction

  // expected prefix byte at a given header position
  function automatic logic [7:0] prefix_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = PREFIX_WORD[31:24];
      2'd1:    b = PREFIX_WORD[23:16];
      2'd2:    b = PREFIX_WORD[15:8];
      default: b = PREFIX_WORD[7:0];
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ design/dpi_if.sv @@
// byte and result channel interfaces of the deframer
`default_nettype none
interface dpi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface dpi_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [2:0]  packet_kind;
  logic [7:0]  pkt_code;
  logic [31:0] next_offset;
  logic [31:0] prev_offset;
  logic [7:0]  payload_byte;
  logic        packet_done;
  logic        accepted;
  logic [31:0] picture_count;

  modport source (output valid, output event_res, output packet_kind, output pkt_code,
                  output next_offset, output prev_offset, output payload_byte,
                  output packet_done, output accepted, output picture_count,
                  input ready);
  modport sink   (input valid, input event_res, input packet_kind, input pkt_code,
                  input next_offset, input prev_offset, input payload_byte,
                  input packet_done, input accepted, input picture_count,
                  output ready);
endinterface
`default_nettype wire

@@ design/dpi_core.sv @@
// deframer state and per-byte step logic
`default_nettype none
`include "dirac_parse_info_deframer_defines.svh"
module dpi_core
  import dpi_pkg::*;
#(
  parameter int OFFSET_BITS = DPI_OFFSET_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [7:0]  data_byte,
  output dpi_result_t result
);

  localparam logic [31:0] OFF_LIMIT = 32'((64'd1 << OFFSET_BITS) - 64'd1);

  logic [23:0]            window_r, window_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [3:0]             hdr_idx_r, hdr_idx_nxt;
  logic [7:0]             code_r, code_nxt;
  logic [31:0]            next_r, next_nxt;
  logic [31:0]            prev_r, prev_nxt;
  logic [OFFSET_BITS-1:0] left_r, left_nxt;
  logic                   seq_r, seq_nxt;
  logic                   sync_r, sync_nxt;
  logic [31:0]            pics_r, pics_nxt;

  logic [31:0] word;
  logic [31:0] off_sat;
  event_t      ev;
  kind_t       kind;
  logic        show;
  logic        done;
  logic [7:0]  pay;
  logic        prefix_phase;

  assign word = {window_r, data_byte};
  assign kind = kind_of(code_nxt);

  // step for one byte
  always_comb begin
    window_nxt  = word[23:0];
    phase_nxt   = phase_r;
    hdr_idx_nxt = hdr_idx_r;
    code_nxt    = code_r;
    next_nxt    = next_r;
    prev_nxt    = prev_r;
    left_nxt    = left_r;
    seq_nxt     = seq_r;
    sync_nxt    = sync_r;
    pics_nxt    = pics_r;
    off_sat     = (next_r > OFF_LIMIT) ? OFF_LIMIT : next_r;
    ev          = EV_HUNT;
    show        = 1'b0;
    done        = 1'b0;
    pay         = 8'h00;
    case (phase_r)
      PH_HEADER: begin
        if (hdr_idx_r < HDR_CODE_IDX) begin
          // prefix check while in sync
          if (data_byte != prefix_byte(hdr_idx_r[1:0])) begin
            ev          = EV_SYNC_LOST;
            phase_nxt   = PH_HUNT;
            hdr_idx_nxt = 4'd0;
            sync_nxt    = 1'b0;
          end else begin
            hdr_idx_nxt = hdr_idx_r + 4'd1;
            if (hdr_idx_nxt == HDR_CODE_IDX) begin
              code_nxt = 8'h00;
              next_nxt = 32'd0;
              prev_nxt = 32'd0;
            end
            ev   = EV_HDR_BYTE;
            show = 1'b1;
          end
        end else begin
          // capture code and big-endian offsets
          if (hdr_idx_r == HDR_CODE_IDX) begin
            code_nxt = data_byte;
          end else if (hdr_idx_r <= HDR_NEXT_LAST) begin
            next_nxt = {next_r[23:0], data_byte};
          end else begin
            prev_nxt = {prev_r[23:0], data_byte};
          end
          show = 1'b1;
          if (hdr_idx_r >= HDR_LAST) begin
            seq_nxt = seq_r | (code_nxt == PC_SEQ_HDR);
            if (seq_nxt && (kind == KIND_PICTURE) && (pics_r != '1)) begin
              pics_nxt = pics_r + 32'd1;
            end
            ev = EV_HDR_DONE;
            if (off_sat <= HEADER_LEN) begin
              done        = 1'b1;
              phase_nxt   = PH_HEADER;
              hdr_idx_nxt = 4'd0;
              sync_nxt    = 1'b1;
            end else begin
              left_nxt    = OFFSET_BITS'(off_sat - HEADER_LEN);
              phase_nxt   = PH_PAYLOAD;
              hdr_idx_nxt = 4'd0;
            end
          end else begin
            hdr_idx_nxt = hdr_idx_r + 4'd1;
            ev          = EV_HDR_BYTE;
          end
        end
      end
      PH_PAYLOAD: begin
        ev   = EV_PAYLOAD;
        pay  = data_byte;
        show = 1'b1;
        if (left_r <= OFFSET_BITS'(1)) begin
          left_nxt    = '0;
          done        = 1'b1;
          phase_nxt   = PH_HEADER;
          hdr_idx_nxt = 4'd0;
          sync_nxt    = 1'b1;
        end else begin
          left_nxt = left_r - OFFSET_BITS'(1);
        end
      end
      default: begin
        // hunting for the prefix in the sliding window
        phase_nxt = PH_HUNT;
        if (word == PREFIX_WORD) begin
          phase_nxt   = PH_HEADER;
          hdr_idx_nxt = HDR_CODE_IDX;
          code_nxt    = 8'h00;
          next_nxt    = 32'd0;
          prev_nxt    = 32'd0;
          ev          = EV_HDR_BYTE;
          show        = 1'b1;
        end
      end
    endcase
  end

  // result of this byte
  always_comb begin
    result.event_res     = ev;
    result.packet_kind   = show ? kind : KIND_SEQ_HDR;
    result.pkt_code      = show ? code_nxt : 8'h00;
    result.next_offset   = show ? next_nxt : 32'd0;
    result.prev_offset   = show ? prev_nxt : 32'd0;
    result.payload_byte  = pay;
    result.packet_done   = done;
    result.accepted      = show && seq_nxt && (kind != KIND_RESERVED);
    result.picture_count = pics_nxt;
  end

  // state registers, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= '0;
      phase_r   <= PH_HUNT;
      hdr_idx_r <= '0;
      code_r    <= '0;
      next_r    <= '0;
      prev_r    <= '0;
      left_r    <= '0;
      seq_r     <= 1'b0;
      sync_r    <= 1'b0;
      pics_r    <= '0;
    end else if (step_en) begin
      window_r  <= window_nxt;
      phase_r   <= phase_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      code_r    <= code_nxt;
      next_r    <= next_nxt;
      prev_r    <= prev_nxt;
      left_r    <= left_nxt;
      seq_r     <= seq_nxt;
      sync_r    <= sync_nxt;
      pics_r    <= pics_nxt;
    end
  end

  // prefix bytes are only checked straight after a packet
  assign prefix_phase = (phase_r == PH_HEADER) && (hdr_idx_r < HDR_CODE_IDX);

  `DPI_ASSERT_NOW(a_sync_not_hunting, sync_r, phase_r != PH_HUNT, "in sync while hunting")
  `DPI_ASSERT_NOW(a_payload_has_bytes, phase_r == PH_PAYLOAD, left_r != '0, "empty payload")
  `DPI_ASSERT_NOW(a_prefix_needs_sync, prefix_phase, sync_r, "prefix check outside sync")
  `DPI_ASSERT_NEXT(a_pictures_monotone, 1'b1, pics_r >= $past(pics_r), "picture count fell")

endmodule
`default_nettype wire

@@ design/dpi_out_reg.sv @@
// result register between the step logic and the result channel
`default_nettype none
module dpi_out_reg
  import dpi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  dpi_result_t result_in,
  input  logic        out_ready,
  output logic        out_valid,
  output dpi_result_t result_out
);

  logic        valid_r, valid_nxt;
  dpi_result_t result_r;

  // valid set on load, cleared once the result transfer completes
  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload holds unless a new result is loaded
  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_in;
    end
  end

  assign out_valid  = valid_r;
  assign result_out = result_r;

endmodule
`default_nettype wire

@@ design/dirac_parse_info_deframer.sv @@
// top level of the parse-info deframer
//
//   channel   dir  handshake          contents
//   in_chan   in   valid/ready        data_byte, one stream byte per transfer
//   out_chan  out  valid/ready        one result per input byte
//
// one result per input byte, valid in the cycle after its input transfer
// sustains one byte per cycle unless stalled; result register sets the latency
// a stalled result holds the input off only until out_chan.ready rises again
// synchronous active-low reset returns the deframer to hunting, count cleared
`default_nettype none
module dirac_parse_info_deframer
  import dpi_pkg::*;
#(
  parameter int OFFSET_BITS = DPI_OFFSET_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  dpi_in_if.sink    in_chan,
  dpi_out_if.source out_chan
);

  logic        out_valid;
  logic        in_xfer;
  dpi_result_t step_result;
  dpi_result_t held_result;

  // accept while the result register is empty or being drained
  assign in_chan.ready = !out_valid || out_chan.ready;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  dpi_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_xfer),
    .data_byte (in_chan.data_byte),
    .result    (step_result)
  );

  dpi_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_xfer),
    .result_in  (step_result),
    .out_ready  (out_chan.ready),
    .out_valid  (out_valid),
    .result_out (held_result)
  );

  // result channel fields
  assign out_chan.valid         = out_valid;
  assign out_chan.event_res     = held_result.event_res;
  assign out_chan.packet_kind   = held_result.packet_kind;
  assign out_chan.pkt_code      = held_result.pkt_code;
  assign out_chan.next_offset   = held_result.next_offset;
  assign out_chan.prev_offset   = held_result.prev_offset;
  assign out_chan.payload_byte  = held_result.payload_byte;
  assign out_chan.packet_done   = held_result.packet_done;
  assign out_chan.accepted      = held_result.accepted;
  assign out_chan.picture_count = held_result.picture_count;

endmodule
`default_nettype wire
